@@ src/sfr_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfr_pkg - shared types and constants for the silence-timed frame receiver
// Field widths, input kind codes and the controller/datapath interface types.
// ---------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned FRAME_DEPTH_DEF = 64;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned LEN_W           = 7;
  localparam int unsigned TICK_W          = 16;
  localparam int unsigned TDATA_W         = 16;

  localparam logic [TICK_W-1:0] TICKS_RESET = 16'hFFFF;

  // Input word kind, carried on tuser
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Controller -> datapath commands
  typedef struct packed {
    logic store_byte;  // write the received byte, restart silence
    logic tick;        // advance the silence counter
    logic rd_en;       // read the frame store at the playback index
    logic advance;     // step the playback index
    logic clear;       // frame delivered: drop it
  } sfr_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic timeout;     // a tick now would end the frame
    logic last;        // playback index is on the final stored byte
  } sfr_status_t;

endpackage

@@ src/silence_timeout_frame_receiver.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// silence_timeout_frame_receiver - UART frame splitter on line silence
// Stores received bytes and plays the frame out after a silent interval.
// ---------------------------------------------------------------------------
// Each input word (a received byte or a timer tick) is taken on its handshake
// while no frame plays out. A tick that brings the silence counter up to
// silence_ticks starts playback: the frame is read from the frame store and
// sent one word per byte: each byte is read from the store (registered, ST_FETCH),
// then presented (ST_SEND) until the output takes it. No input word is
// taken during playback; the tick that ended the frame is the last one
// before it. Bytes beyond FRAME_DEPTH are dropped and flag the frame as
// truncated. The frame store needs no clearing after reset.
module silence_timeout_frame_receiver #(
  parameter int unsigned FRAME_DEPTH = sfr_pkg::FRAME_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration: silence_ticks
  input  logic                        cfg_we_i,
  input  logic [sfr_pkg::TICK_W-1:0]  cfg_wdata_i,
  // input words
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [sfr_pkg::BYTE_W-1:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic                        s_axis_tuser_i,   // [0] kind
  // frame words
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [sfr_pkg::TDATA_W-1:0] m_axis_tdata_o,   // [7:0] frame_byte,
                                                        // [14:8] frame_length
  output logic                        m_axis_tlast_o,   // last_byte
  output logic                        m_axis_tuser_o    // [0] truncated
);

  import sfr_pkg::*;

  sfr_cmd_t          cmd;
  sfr_status_t       status;
  logic [BYTE_W-1:0] frame_byte;
  logic [LEN_W-1:0]  frame_length;
  logic              truncated;

  // controller
  sfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_kind_i   (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_last_o  (m_axis_tlast_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath
  sfr_datapath #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .rx_byte_i      (s_axis_tdata_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .frame_byte_o   (frame_byte),
    .frame_length_o (frame_length),
    .truncated_o    (truncated)
  );

  // output word packing
  assign m_axis_tdata_o = {{(TDATA_W - BYTE_W - LEN_W){1'b0}}, frame_length, frame_byte};
  assign m_axis_tuser_o = truncated;

  // input and output never both open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tvalid_o && s_axis_tready_o))
    else $error("input accepted during playback");

  // delivering the final byte reopens the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> s_axis_tready_o)
    else $error("input not reopened after frame end");

  // a played frame always holds at least one byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[14:8] != 7'd0))
    else $error("empty frame played out");

  // a timing-out tick starts playback once the fetch state (ST_FETCH) has passed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.tick && status.timeout) |=> ##1 m_axis_tvalid_o)
    else $error("playback did not start after timeout");

endmodule

@@ src/sfr_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfr_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module sfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/sfr_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfr_datapath - frame store, counters and timeout register
// Holds the frame, the silence counter and the playback index.
// ---------------------------------------------------------------------------
module sfr_datapath #(
  parameter int unsigned FRAME_DEPTH = sfr_pkg::FRAME_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sfr_pkg::TICK_W-1:0]    cfg_wdata_i,
  input  logic [sfr_pkg::BYTE_W-1:0]    rx_byte_i,
  input  sfr_pkg::sfr_cmd_t             cmd_i,
  output sfr_pkg::sfr_status_t          status_o,
  output logic [sfr_pkg::BYTE_W-1:0]    frame_byte_o,
  output logic [sfr_pkg::LEN_W-1:0]     frame_length_o,
  output logic                          truncated_o
);

  import sfr_pkg::*;

  localparam int unsigned AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam logic [LEN_W-1:0] DEPTH_CNT = LEN_W'(FRAME_DEPTH);

  logic [TICK_W-1:0] ticks_q;
  logic [TICK_W-1:0] silence_q, silence_d, silence_inc;
  logic [LEN_W-1:0]  count_q, count_d;
  logic              open_q, open_d;
  logic              ovf_q, ovf_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic              has_room;
  logic              ram_we;

  // timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= TICKS_RESET;
    end else if (cfg_we_i) begin
      ticks_q <= cfg_wdata_i;
    end
  end

  // saturating silence increment and timeout check
  assign silence_inc = (silence_q == '1) ? silence_q : silence_q + 1'b1;
  assign has_room    = (count_q < DEPTH_CNT);
  assign ram_we      = cmd_i.store_byte && has_room;

  assign status_o.timeout = open_q && (silence_inc >= ticks_q);
  assign status_o.last    = ((LEN_W'(idx_q) + 1'b1) == count_q);

  // frame state update
  always_comb begin
    silence_d = silence_q;
    count_d   = count_q;
    open_d    = open_q;
    ovf_d     = ovf_q;
    idx_d     = idx_q;
    if (cmd_i.store_byte) begin
      if (has_room) begin
        count_d = count_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
      open_d    = 1'b1;
      silence_d = '0;
    end
    if (cmd_i.tick && open_q) begin
      silence_d = silence_inc;
    end
    if (cmd_i.advance) begin
      idx_d = idx_q + 1'b1;
    end
    if (cmd_i.clear) begin
      silence_d = '0;
      count_d   = '0;
      open_d    = 1'b0;
      ovf_d     = 1'b0;
      idx_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silence_q <= '0;
      count_q   <= '0;
      open_q    <= 1'b0;
      ovf_q     <= 1'b0;
      idx_q     <= '0;
    end else begin
      silence_q <= silence_d;
      count_q   <= count_d;
      open_q    <= open_d;
      ovf_q     <= ovf_d;
      idx_q     <= idx_d;
    end
  end

  // frame store
  sfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q),
    .rdata_o (frame_byte_o)
  );

  assign frame_length_o = count_q;
  assign truncated_o    = ovf_q;

endmodule

@@ src/sfr_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfr_ctrl - receive / playback controller
// Takes input words while idle, and plays a timed-out frame byte by byte.
// ---------------------------------------------------------------------------
module sfr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 in_kind_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 out_last_o,
  input  sfr_pkg::sfr_status_t status_i,
  output sfr_pkg::sfr_cmd_t    cmd_o
);

  import sfr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SEND
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   valid_q;
  logic   in_acc;
  logic   out_acc;

  assign in_acc  = in_valid_i && ready_q;
  assign out_acc = valid_q && out_ready_i;

  // commands
  assign cmd_o.store_byte = in_acc && (in_kind_i == KIND_BYTE);
  assign cmd_o.tick       = in_acc && (in_kind_i == KIND_TICK);
  assign cmd_o.rd_en      = (state_q == ST_FETCH);
  assign cmd_o.advance    = out_acc && !status_i.last;
  assign cmd_o.clear      = out_acc && status_i.last;

  // state and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc && (in_kind_i == KIND_TICK) && status_i.timeout) begin
            state_q <= ST_FETCH;
            ready_q <= 1'b0;
          end
        end
        ST_FETCH: begin
          state_q <= ST_SEND;
          valid_q <= 1'b1;
        end
        ST_SEND: begin
          if (out_acc) begin
            valid_q <= 1'b0;
            if (status_i.last) begin
              state_q <= ST_IDLE;
              ready_q <= 1'b1;
            end else begin
              state_q <= ST_FETCH;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b1;
          valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o  = ready_q;
  assign out_valid_o = valid_q;
  assign out_last_o  = valid_q && status_i.last;

endmodule

@@ tb/sv/tb_silence_timeout_frame_receiver.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_silence_timeout_frame_receiver - self-checking bench for the frame receiver
// Drives received bytes and timer ticks, predicts frame words from an internal
// model of the silence timer and frame store (or takes them from the directed
// table), and compares the played-out words field by field. Gaps and stalls vary on both sides.
// ---------------------------------------------------------------------------
module tb_silence_timeout_frame_receiver;
  import sfr_pkg::*;

  localparam int unsigned DEPTH         = FRAME_DEPTH_DEF;
  localparam int          ITEM_TARGET   = 500;
  localparam int          SETTLE_CYCLES = 10;
  localparam int          IDLE_LIMIT    = 4000;

  // one played-out frame word
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic              last;
    logic              trunc;
  } frame_word_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_BYTE, ROW_TICK} row_op_e;

  typedef struct packed {
    row_op_e       op;
    logic [15:0]   value;
    logic          has_exp;
    frame_word_t   exp;
  } dir_row_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [TICK_W-1:0]    cfg_wdata_i     = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [BYTE_W-1:0]    s_axis_tdata_i  = '0;   // [7:0] rx_byte
  logic                 s_axis_tuser_i  = 1'b0; // [0] kind
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata_o;         // [7:0] frame_byte, [14:8] frame_length
  logic                 m_axis_tlast_o;         // last_byte
  logic                 m_axis_tuser_o;         // [0] truncated

  // model of the receiver
  logic [BYTE_W-1:0]    rx_store [DEPTH];
  int unsigned          rx_count    = 0;
  logic [TICK_W-1:0]    quiet_count = '0;
  logic                 rx_open     = 1'b0;
  logic                 rx_dropped  = 1'b0;
  logic [TICK_W-1:0]    quiet_limit = TICKS_RESET;

  frame_word_t          frame_words_q [$];
  dir_row_t             dir_rows [$];

  int  errors        = 0;
  int  items_taken   = 0;
  int  words_checked = 0;
  int  frames_seen   = 0;
  int  trunc_frames  = 0;
  int  idle_cycles   = 0;
  int  stall_left    = 0;
  logic src_gaps     = 1'b0;
  logic sink_stalls  = 1'b0;

  silence_timeout_frame_receiver dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // advance the model by one word; -1 when the word is ignored
  function automatic int predict_word(input logic kind, input logic [BYTE_W-1:0] b,
                                      input logic push);
    int unsigned n;
    frame_word_t w;
    if (kind == KIND_BYTE) begin
      if (rx_count < DEPTH) begin
        rx_store[rx_count] = b;
        rx_count++;
      end else begin
        rx_dropped = 1'b1;
      end
      rx_open     = 1'b1;
      quiet_count = '0;
      return 0;
    end
    if (!rx_open) return -1;
    if (quiet_count != 16'hFFFF) quiet_count++;
    if (quiet_count < quiet_limit) return 0;
    // silence reached: play the frame out
    n = rx_count;
    if (push) begin
      for (int k = 0; k < n; k++) begin
        w.data  = rx_store[k];
        w.len   = n[LEN_W-1:0];
        w.last  = (k + 1 == n);
        w.trunc = rx_dropped;
        frame_words_q.push_back(w);
      end
    end
    frames_seen++;
    if (rx_dropped) trunc_frames++;
    rx_count    = 0;
    quiet_count = '0;
    rx_open     = 1'b0;
    rx_dropped  = 1'b0;
    return n;
  endfunction

  // present one word, wait for the handshake, update the model
  task automatic send_word(input logic kind, input logic [BYTE_W-1:0] b, input logic push);
    int gap;
    int n;
    gap = src_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    n = predict_word(kind, b, push);
    if (n >= 0) items_taken++;
  endtask

  // hold off until every frame word is out, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (frame_words_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_ticks(input logic [TICK_W-1:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    quiet_limit = v;
    cfg_we_i    <= 1'b0;
  endtask

  task automatic add_row(input row_op_e op, input logic [15:0] value, input logic has_exp,
                         input logic [BYTE_W-1:0] d, input logic tr);
    dir_row_t row;
    row.op        = op;
    row.value     = value;
    row.has_exp   = has_exp;
    row.exp.data  = d;
    row.exp.len   = 7'd1;
    row.exp.last  = 1'b1;
    row.exp.trunc = tr;
    dir_rows.push_back(row);
  endtask

  // a frame of random bytes with sub-timeout silences (now and then a full timeout that splits it), then the timeout
  task automatic send_frame(input int len);
    int unsigned lim;
    lim = (quiet_limit == 0) ? 1 : quiet_limit;
    for (int i = 0; i < len; i++) begin
      send_word(KIND_BYTE, BYTE_W'($urandom_range(0, 255)), 1'b1);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(0, lim - 1))
          send_word(KIND_TICK, BYTE_W'($urandom_range(0, 255)), 1'b1);
      else if ($urandom_range(0, 31) == 0)
        repeat (lim) send_word(KIND_TICK, BYTE_W'($urandom_range(0, 255)), 1'b1);  // splits
    end
    repeat (lim + $urandom_range(0, 2))
      send_word(KIND_TICK, BYTE_W'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 8);
    if (r < 16) return $urandom_range(9, 40);
    if (r < 18) return $urandom_range(63, 65);
    return $urandom_range(60, 72);
  endfunction

  // sink stalls
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left      <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
      stall_left      <= pick_gap();
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: word %0d %s expected %0h actual %0h", $time, words_checked, name,
               exp_v, act_v);
    end
  endfunction

  // frame word checker
  always @(posedge clk_i) begin
    frame_word_t w;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (frame_words_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected frame word, expected none, actual data %0h len %0d",
                 $time, m_axis_tdata_o[7:0], m_axis_tdata_o[14:8]);
      end else begin
        w = frame_words_q.pop_front();
        check_field("frame_byte", w.data, m_axis_tdata_o[7:0]);
        check_field("frame_length", w.len, m_axis_tdata_o[14:8]);
        check_field("last_byte", w.last, m_axis_tlast_o);
        check_field("truncated", w.trunc, m_axis_tuser_o);
      end
      words_checked++;
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("silence_timeout_frame_receiver: mismatch");
      $finish;
    end
  end

  initial begin
    dir_row_t row;
    int r;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset timeout holds the frame through a few ticks; a lower one lets the next tick end it
    send_word(KIND_BYTE, 8'h00, 1'b1);
    send_word(KIND_BYTE, 8'hFF, 1'b1);
    repeat (8) send_word(KIND_TICK, 8'h00, 1'b1);
    write_ticks(16'd1);
    send_word(KIND_TICK, 8'h00, 1'b1);

    // directed table
    add_row(ROW_CFG,  16'd1,    1'b0, 8'h00, 1'b0);
    add_row(ROW_TICK, 16'h00,   1'b0, 8'h00, 1'b0);  // no frame open: ignored
    add_row(ROW_BYTE, 16'h00,   1'b0, 8'h00, 1'b0);
    add_row(ROW_TICK, 16'hFF,   1'b1, 8'h00, 1'b0);
    add_row(ROW_BYTE, 16'hFF,   1'b0, 8'h00, 1'b0);
    add_row(ROW_TICK, 16'h00,   1'b1, 8'hFF, 1'b0);
    add_row(ROW_CFG,  16'd0,    1'b0, 8'h00, 1'b0);  // zero timeout acts as one
    add_row(ROW_BYTE, 16'hA5,   1'b0, 8'h00, 1'b0);
    add_row(ROW_TICK, 16'h00,   1'b1, 8'hA5, 1'b0);
    add_row(ROW_CFG,  16'd3,    1'b0, 8'h00, 1'b0);
    add_row(ROW_BYTE, 16'h5A,   1'b0, 8'h00, 1'b0);
    add_row(ROW_BYTE, 16'h3C,   1'b0, 8'h00, 1'b0);
    add_row(ROW_TICK, 16'h00,   1'b0, 8'h00, 1'b0);
    add_row(ROW_TICK, 16'h00,   1'b0, 8'h00, 1'b0);
    add_row(ROW_BYTE, 16'h81,   1'b0, 8'h00, 1'b0);  // restarts the silence
    add_row(ROW_TICK, 16'h00,   1'b0, 8'h00, 1'b0);
    add_row(ROW_TICK, 16'h00,   1'b0, 8'h00, 1'b0);
    add_row(ROW_TICK, 16'h00,   1'b0, 8'h00, 1'b0);
    add_row(ROW_CFG,  16'd5,    1'b0, 8'h00, 1'b0);
    add_row(ROW_BYTE, 16'h11,   1'b0, 8'h00, 1'b0);
    add_row(ROW_TICK, 16'h00,   1'b0, 8'h00, 1'b0);
    add_row(ROW_TICK, 16'h00,   1'b0, 8'h00, 1'b0);
    add_row(ROW_TICK, 16'h00,   1'b0, 8'h00, 1'b0);
    add_row(ROW_CFG,  16'd2,    1'b0, 8'h00, 1'b0);  // lowered below the count mid-frame
    add_row(ROW_TICK, 16'h00,   1'b0, 8'h00, 1'b0);
    add_row(ROW_CFG,  16'hFFFF, 1'b0, 8'h00, 1'b0);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      case (row.op)
        ROW_CFG:  write_ticks(row.value);
        ROW_BYTE: send_word(KIND_BYTE, row.value[7:0], 1'b1);
        default: begin
          send_word(KIND_TICK, row.value[7:0], !row.has_exp);
          if (row.has_exp) frame_words_q.push_back(row.exp);
        end
      endcase
    end

    // full store: exactly full, then one over (a random split can cut either frame)
    write_ticks(16'd2);
    send_frame(64);
    send_frame(65);

    // random phases of well-formed frames with some noise
    while (items_taken < ITEM_TARGET) begin
      r = $urandom_range(0, 9);
      if (r == 0)      write_ticks(16'd0);
      else if (r == 1) write_ticks(16'd1);
      else if (r < 7)  write_ticks(TICK_W'($urandom_range(2, 6)));
      else             write_ticks(TICK_W'($urandom_range(7, 20)));
      src_gaps    = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(5, 15)) send_word(1'($urandom_range(0, 1)),
                                                   BYTE_W'($urandom_range(0, 255)), 1'b1);
        else
          send_frame(pick_len());
      end
    end

    // maximum timeout written explicitly, then lowered under the running count
    src_gaps    = 1'b0;
    sink_stalls = 1'b1;
    write_ticks(16'hFFFF);
    send_word(KIND_BYTE, BYTE_W'($urandom_range(0, 255)), 1'b1);
    repeat (8) send_word(KIND_TICK, 8'h00, 1'b1);
    write_ticks(16'd4);
    send_word(KIND_TICK, 8'h00, 1'b1);

    wait_idle();
    $display("Run covered %0d input words and %0d frames (%0d truncated).",
             items_taken, frames_seen, trunc_frames);
    $display("%0d frame words checked over silence timeouts from 0 to 65535.", words_checked);
    if (errors == 0)
      $display("silence_timeout_frame_receiver: match");
    else
      $display("silence_timeout_frame_receiver: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
src/sfr_pkg.sv
src/sfr_ram.sv
src/sfr_datapath.sv
src/sfr_ctrl.sv
src/silence_timeout_frame_receiver.sv
tb/sv/tb_silence_timeout_frame_receiver.sv
